/* rtl/pswa_pkg.sv */
`timescale 1ns / 1ps
package pswa_pkg;

  // fixed field widths of the channels
  localparam int MASS_BITS   = 32;
  localparam int WEIGHT_BITS = 64;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_TAKE,
    CMD_MUL_LOAD,
    CMD_MUL_STEP,
    CMD_DIFF,
    CMD_SQRT_LOAD,
    CMD_SQRT_STEP,
    CMD_DIV_LOAD,
    CMD_DIV_STEP,
    CMD_FINISH
  } op_t;

  // which product the shared multiplier forms
  typedef enum logic [2:0] {
    MS_AA,
    MS_SS,
    MS_DD,
    MS_XY,
    MS_PQ
  } mul_sel_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic unph;
    logic mul_zero;
    logic sqrt_done;
    logic div_done;
    logic out_block;
  } status_t;

endpackage

/* rtl/pswa_if.sv */
`timescale 1ns / 1ps
// stage request channel
interface pswa_stage_if;
  import pswa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 first_of_event;
  logic                 last_of_event;
  logic [MASS_BITS-1:0] invariant_mass;
  logic [MASS_BITS-1:0] particle_mass;

  modport source (output valid, first_of_event, last_of_event, invariant_mass, particle_mass,
                  input ready);
  modport sink   (input valid, first_of_event, last_of_event, invariant_mass, particle_mass,
                  output ready);
endinterface

// weight result channel
interface pswa_result_if;
  import pswa_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] weight;
  logic                   unphysical;
  logic                   saturated;

  modport source (output valid, weight, unphysical, saturated, input ready);
  modport sink   (input valid, weight, unphysical, saturated, output ready);
endinterface

/* rtl/pswa_ctrl.sv */
`timescale 1ns / 1ps
module pswa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pswa_pkg::status_t status,
  output pswa_pkg::cmd_t    cmd
);
  import pswa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL_LD,
    S_MUL_RUN,
    S_DIFF,
    S_CHECK,
    S_SQRT_LD,
    S_SQRT_RUN,
    S_DIV_LD,
    S_DIV_RUN,
    S_FINISH
  } state_t;

  state_t   state;
  mul_sel_t sel;

  // sequence of one stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= MS_AA;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (status.first || status.unph) begin
            state <= S_FINISH;
          end else begin
            sel   <= MS_AA;
            state <= S_MUL_LD;
          end
        end
        S_MUL_LD: state <= S_MUL_RUN;
        S_MUL_RUN: begin
          if (status.mul_zero) begin
            case (sel)
              MS_AA: begin
                sel   <= MS_SS;
                state <= S_MUL_LD;
              end
              MS_SS: begin
                sel   <= MS_DD;
                state <= S_MUL_LD;
              end
              MS_DD: state <= S_DIFF;
              MS_XY: state <= S_SQRT_LD;
              default: state <= S_FINISH;
            endcase
          end
        end
        S_DIFF: state <= S_CHECK;
        S_CHECK: begin
          if (status.unph) begin
            state <= S_FINISH;
          end else begin
            sel   <= MS_XY;
            state <= S_MUL_LD;
          end
        end
        S_SQRT_LD: state <= S_SQRT_RUN;
        S_SQRT_RUN: begin
          if (status.sqrt_done) state <= S_DIV_LD;
        end
        S_DIV_LD: state <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (status.div_done) begin
            sel   <= MS_PQ;
            state <= S_MUL_LD;
          end
        end
        S_FINISH: begin
          if (!status.out_block) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd.sel = sel;
    case (state)
      S_IDLE:     cmd.op = CMD_TAKE;
      S_MUL_LD:   cmd.op = CMD_MUL_LOAD;
      S_MUL_RUN:  cmd.op = CMD_MUL_STEP;
      S_DIFF:     cmd.op = CMD_DIFF;
      S_SQRT_LD:  cmd.op = CMD_SQRT_LOAD;
      S_SQRT_RUN: cmd.op = CMD_SQRT_STEP;
      S_DIV_LD:   cmd.op = CMD_DIV_LOAD;
      S_DIV_RUN:  cmd.op = CMD_DIV_STEP;
      S_FINISH:   cmd.op = CMD_FINISH;
      default:    cmd.op = CMD_IDLE;
    endcase
  end

endmodule

/* rtl/pswa_dp.sv */
`timescale 1ns / 1ps
module pswa_dp #(
  parameter int MASS_WIDTH     = 32,
  parameter int MASS_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  pswa_pkg::cmd_t                     cmd,
  output pswa_pkg::status_t                  status,
  input  logic                               in_valid,
  input  logic                               in_first,
  input  logic                               in_last,
  input  logic [pswa_pkg::MASS_BITS-1:0]     in_a,
  input  logic [pswa_pkg::MASS_BITS-1:0]     in_c,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pswa_pkg::WEIGHT_BITS-1:0]   weight,
  output logic                               unphysical,
  output logic                               saturated
);
  import pswa_pkg::*;

  localparam int W   = MASS_WIDTH;
  localparam int SQW = 2 * W + 2;
  localparam int SH  = 64 - 2 * MASS_FRAC_BITS;
  localparam int RW  = 2 * SQW + SH;
  localparam int QW  = (RW + 1) / 2;
  localparam int RWE = 2 * QW;
  localparam int PW  = (RWE > 64 + QW) ? RWE : 64 + QW;
  localparam int CW  = $clog2(QW + 1);
  localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;

  // captured request and event state
  logic [W-1:0]   a_r, c_r, prev;
  logic           first_r, last_r;
  logic [63:0]    running;
  logic           unph, sat;

  // shift-add multiplier
  logic [PW-1:0]  mcand, mplier, acc;
  logic [PW-1:0]  ld_mcand, ld_mplier;

  // squares and differences
  logic [SQW-1:0] a2, s2, d2, xm, ym;
  logic [W:0]     sum;
  logic [W-1:0]   dif;
  logic           x_neg, x_pos, y_neg, y_pos;

  // square root and divide
  logic [RWE-1:0] num, res, bitm, sq_t;
  logic           sq_ge;
  logic [W:0]     rem, den;
  logic [W+1:0]   rem_sh, rem_sub;
  logic           div_ge;
  logic [QW-1:0]  quo;
  logic [CW-1:0]  cnt;

  // product update and event close
  logic           over;
  logic [63:0]    new_run, f_run;
  logic           f_unph, f_sat;
  logic           emit;

  assign sum = {1'b0, prev} + {1'b0, c_r};
  assign dif = (prev >= c_r) ? (prev - c_r) : (c_r - prev);

  // multiplier operand select
  always_comb begin
    case (cmd.sel)
      MS_AA: begin
        ld_mcand  = PW'(a_r);
        ld_mplier = PW'(a_r);
      end
      MS_SS: begin
        ld_mcand  = PW'(sum);
        ld_mplier = PW'(sum);
      end
      MS_DD: begin
        ld_mcand  = PW'(dif);
        ld_mplier = PW'(dif);
      end
      MS_XY: begin
        ld_mcand  = PW'(xm);
        ld_mplier = PW'(ym);
      end
      MS_PQ: begin
        ld_mcand  = PW'(running);
        ld_mplier = PW'(quo);
      end
      default: begin
        ld_mcand  = '0;
        ld_mplier = '0;
      end
    endcase
  end

  assign x_neg = s2 > a2;
  assign x_pos = a2 > s2;
  assign y_neg = d2 > a2;
  assign y_pos = a2 > d2;

  assign sq_t  = res + bitm;
  assign sq_ge = num >= sq_t;

  assign den     = {a_r, 1'b0};
  assign rem_sh  = {rem, quo[QW-1]};
  assign div_ge  = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  assign over    = |acc[PW-1:96];
  assign new_run = over ? {64{1'b1}} : acc[95:32];

  assign f_run  = first_r ? ONE_Q : running;
  assign f_unph = first_r ? 1'b0 : unph;
  assign f_sat  = first_r ? 1'b0 : sat;

  // last stage closes the event once the result register is free
  assign emit = (cmd.op == CMD_FINISH) && last_r && (!out_valid || out_ready);

  assign status.first     = first_r;
  assign status.unph      = unph;
  assign status.mul_zero  = (mplier == '0);
  assign status.sqrt_done = (bitm == '0);
  assign status.div_done  = (cnt == '0);
  assign status.out_block = last_r && out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      running   <= ONE_Q;
      unph      <= 1'b0;
      sat       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !emit) out_valid <= 1'b0;
      case (cmd.op)
        // capture request
        CMD_TAKE: begin
          if (in_valid) begin
            a_r     <= W'(in_a);
            c_r     <= W'(in_c);
            first_r <= in_first;
            last_r  <= in_last;
          end
        end
        CMD_MUL_LOAD: begin
          mcand  <= ld_mcand;
          mplier <= ld_mplier;
          acc    <= '0;
        end
        // one multiplier bit, or write back when done
        CMD_MUL_STEP: begin
          if (mplier != '0) begin
            if (mplier[0]) acc <= acc + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end else begin
            case (cmd.sel)
              MS_AA: a2 <= acc[SQW-1:0];
              MS_SS: s2 <= acc[SQW-1:0];
              MS_DD: d2 <= acc[SQW-1:0];
              MS_XY: num <= acc[RWE-1:0] << SH;
              MS_PQ: begin
                running <= new_run;
                if (over) sat <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        // radicand factor magnitudes and physical check
        CMD_DIFF: begin
          xm <= x_neg ? (s2 - a2) : (a2 - s2);
          ym <= y_neg ? (d2 - a2) : (a2 - d2);
          if ((a_r == '0) || (x_neg && y_pos) || (x_pos && y_neg)) begin
            unph    <= 1'b1;
            running <= '0;
          end
        end
        CMD_SQRT_LOAD: begin
          res  <= '0;
          bitm <= {2'b01, {(RWE-2){1'b0}}};
        end
        // one root bit per cycle
        CMD_SQRT_STEP: begin
          if (bitm != '0) begin
            if (sq_ge) begin
              num <= num - sq_t;
              res <= (res >> 1) + bitm;
            end else begin
              res <= res >> 1;
            end
            bitm <= bitm >> 2;
          end
        end
        CMD_DIV_LOAD: begin
          rem <= '0;
          quo <= res[QW-1:0];
          cnt <= CW'(QW);
        end
        // restoring divide by 2a, one quotient bit per cycle
        CMD_DIV_STEP: begin
          if (cnt != '0) begin
            rem <= div_ge ? rem_sub[W:0] : rem_sh[W:0];
            quo <= {quo[QW-2:0], div_ge};
            cnt <= cnt - 1'b1;
          end
        end
        // close the stage, emit on the last one
        CMD_FINISH: begin
          if (last_r) begin
            if (emit) begin
              weight     <= f_unph ? '0 : f_run;
              unphysical <= f_unph;
              saturated  <= f_sat;
              out_valid  <= 1'b1;
              prev       <= '0;
              running    <= ONE_Q;
              unph       <= 1'b0;
              sat        <= 1'b0;
            end
          end else begin
            prev    <= a_r;
            running <= f_run;
            unph    <= f_unph;
            sat     <= f_sat;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/phase_space_weight_accumulator.sv */
`timescale 1ns / 1ps
// one stage request is taken at a time; first-of-event or unphysical stages skip the arithmetic
// a full stage runs three squarings, the radicand product, a bit-serial square root, a
// restoring divide by 2a and the final product; the squarings and products share one
// bit-serial shift-add unit, and the root and divide have their own bit-serial logic
// the weight appears in the result register the cycle after the last stage finishes
// synchronous reset clears the event state to product 1.0 and drops any pending result
module phase_space_weight_accumulator #(
  parameter int MASS_WIDTH     = 32,
  parameter int MASS_FRAC_BITS = 16
) (
  input logic           clk,
  input logic           rst,
  pswa_stage_if.sink    stage,
  pswa_result_if.source result
);
  import pswa_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign stage.ready = (cmd.op == CMD_TAKE);

  pswa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage.valid),
    .status   (status),
    .cmd      (cmd)
  );

  pswa_dp #(
    .MASS_WIDTH     (MASS_WIDTH),
    .MASS_FRAC_BITS (MASS_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_valid   (stage.valid),
    .in_first   (stage.first_of_event),
    .in_last    (stage.last_of_event),
    .in_a       (stage.invariant_mass),
    .in_c       (stage.particle_mass),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .weight     (result.weight),
    .unphysical (result.unphysical),
    .saturated  (result.saturated)
  );

endmodule

/* rtl/pswa_chk.sv */
`timescale 1ns / 1ps
module pswa_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [pswa_pkg::WEIGHT_BITS-1:0] weight,
  input logic                             unphysical
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight))
    else $error("result dropped or changed while stalled");

  // unphysical events carry zero weight
  a_unph_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && unphysical |-> weight == '0)
    else $error("unphysical result with nonzero weight");

  // one stage in flight at a time
  a_one_stage: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while a stage is running");

  // reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind phase_space_weight_accumulator pswa_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (stage.valid),
  .in_ready   (stage.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .weight     (result.weight),
  .unphysical (result.unphysical)
);
